// File: src/dihedral_pkg.sv
// shared types and constants for the torsion angle pipeline
// no dependencies
package dihedral_pkg;

    localparam int NORM_EXP     = 29;
    localparam int CROSS_EXP    = 30;
    localparam int ANG_FRAC     = 16;
    localparam int HALF_TURN_CD = 18000;
    localparam int CORDIC_W     = 72;
    localparam int ANGLE_W      = 34;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd589824000;

    function automatic logic signed [ANGLE_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [ANGLE_W-1:0] r;
        case (i)
            5'd0:  r = 34'sd294912000;
            5'd1:  r = 34'sd174096719;
            5'd2:  r = 34'sd91987925;
            5'd3:  r = 34'sd46694507;
            5'd4:  r = 34'sd23437865;
            5'd5:  r = 34'sd11730358;
            5'd6:  r = 34'sd5866610;
            5'd7:  r = 34'sd2933484;
            5'd8:  r = 34'sd1466764;
            5'd9:  r = 34'sd733385;
            5'd10: r = 34'sd366693;
            5'd11: r = 34'sd183346;
            5'd12: r = 34'sd91673;
            5'd13: r = 34'sd45837;
            5'd14: r = 34'sd22918;
            5'd15: r = 34'sd11459;
            5'd16: r = 34'sd5730;
            5'd17: r = 34'sd2865;
            5'd18: r = 34'sd1432;
            5'd19: r = 34'sd716;
            5'd20: r = 34'sd358;
            5'd21: r = 34'sd179;
            5'd22: r = 34'sd90;
            5'd23: r = 34'sd45;
            5'd24: r = 34'sd22;
            5'd25: r = 34'sd11;
            5'd26: r = 34'sd6;
            5'd27: r = 34'sd3;
            5'd28: r = 34'sd1;
            5'd29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: src/dihedral_angle_four_points.sv
// top level: torsion angle of four points, vector front end, square root,
// cordic vectoring chain and output register; depends on dihedral_pkg and submodules
//
// usage: present twelve signed coordinates with in_valid; a transaction is taken
// when in_valid and in_ready are both high. one result per input transaction
// appears on out_valid/out_ready with angle_centideg and degenerate.
// throughput: one transaction per cycle while the receiver does not stall; every pipeline stage holds one item.
// pipeline: 8 front end stages, 33 square root stages, ANGLE_ITERATIONS cordic
// stages and 1 output stage. the depth is set by the bitwise square root and the
// cordic step chain.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready falls; nothing is lost or repeated. in_ready is high whenever the
// output register is empty or being taken.
// reset clears all valid bits; data registers are not reset.
module dihedral_angle_four_points
    import dihedral_pkg::*;
#(
    parameter int COORD_WIDTH      = 24,
    parameter int ANGLE_ITERATIONS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] p1_x,
    input  logic signed [COORD_WIDTH-1:0] p1_y,
    input  logic signed [COORD_WIDTH-1:0] p1_z,
    input  logic signed [COORD_WIDTH-1:0] p2_x,
    input  logic signed [COORD_WIDTH-1:0] p2_y,
    input  logic signed [COORD_WIDTH-1:0] p2_z,
    input  logic signed [COORD_WIDTH-1:0] p3_x,
    input  logic signed [COORD_WIDTH-1:0] p3_y,
    input  logic signed [COORD_WIDTH-1:0] p3_z,
    input  logic signed [COORD_WIDTH-1:0] p4_x,
    input  logic signed [COORD_WIDTH-1:0] p4_y,
    input  logic signed [COORD_WIDTH-1:0] p4_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            angle_centideg,
    output logic                          degenerate
);
    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    logic signed [COORD_WIDTH-1:0] p [12];
    assign p = '{p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z};

    logic f_valid, f_neg, f_degen;
    logic signed [CORDIC_W-1:0] f_x;
    logic [63:0] f_q;
    logic [6:0] f_s;

    dihedral_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .p(p),
        .out_valid(f_valid), .out_x(f_x), .out_q(f_q), .out_s(f_s),
        .out_neg(f_neg), .out_degen(f_degen)
    );

    logic c_valid [ANGLE_ITERATIONS+1];
    logic signed [CORDIC_W-1:0] c_x [ANGLE_ITERATIONS+1], c_y [ANGLE_ITERATIONS+1];
    logic signed [ANGLE_W-1:0] c_z [ANGLE_ITERATIONS+1];
    logic c_neg [ANGLE_ITERATIONS+1], c_degen [ANGLE_ITERATIONS+1];
    logic signed [CORDIC_W-1:0] s_x;
    logic s_fold;

    dihedral_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid), .in_x(f_x),
        .in_q(f_q), .in_s(f_s), .in_neg(f_neg), .in_degen(f_degen),
        .out_valid(c_valid[0]), .out_x(s_x), .out_y(c_y[0]), .out_fold(s_fold),
        .out_neg(c_neg[0]), .out_degen(c_degen[0])
    );

    assign c_x[0] = s_x;
    assign c_z[0] = s_fold ? QUARTER_TURN : ANGLE_W'(0);

    for (genvar g = 0; g < ANGLE_ITERATIONS; g++)
    begin : g_cordic
        dihedral_cordic_stage #(.STEP(g)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c_valid[g]),
            .in_x(c_x[g]), .in_y(c_y[g]), .in_z(c_z[g]),
            .in_neg(c_neg[g]), .in_degen(c_degen[g]),
            .out_valid(c_valid[g+1]), .out_x(c_x[g+1]), .out_y(c_y[g+1]),
            .out_z(c_z[g+1]), .out_neg(c_neg[g+1]), .out_degen(c_degen[g+1])
        );
    end

    logic signed [ANGLE_W-1:0] zf, zr;
    logic signed [ANGLE_W-1:0] zc;
    logic signed [15:0] angle_next;
    always_comb
    begin
        zf = c_z[ANGLE_ITERATIONS];
        if (zf >= 0)
            zr = (zf + (ANGLE_W'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
        else
            zr = -((-zf + (ANGLE_W'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC);
        if (zr < 0)
            zc = '0;
        else if (zr > ANGLE_W'(HALF_TURN_CD))
            zc = ANGLE_W'(HALF_TURN_CD);
        else
            zc = zr;
        if (c_degen[ANGLE_ITERATIONS])
            angle_next = '0;
        else if (c_neg[ANGLE_ITERATIONS])
            angle_next = -16'(zc);
        else
            angle_next = 16'(zc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= c_valid[ANGLE_ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_centideg <= angle_next;
            degenerate <= c_degen[ANGLE_ITERATIONS];
        end
    end

    ap_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle_centideg <= 16'sd18000 && angle_centideg >= -16'sd18000))
        else $error("angle out of range");
    ap_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> angle_centideg == 16'sd0)
        else $error("degenerate with nonzero angle");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(angle_centideg))
        else $error("result dropped under stall");
    ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready mismatch");
endmodule

// File: src/dihedral_cordic_stage.sv
// one cordic vectoring step with its pipeline register
// depends on dihedral_pkg
module dihedral_cordic_stage
    import dihedral_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [CORDIC_W-1:0] in_x,
    input  logic signed [CORDIC_W-1:0] in_y,
    input  logic signed [ANGLE_W-1:0]  in_z,
    input  logic                       in_neg,
    input  logic                       in_degen,
    output logic                       out_valid,
    output logic signed [CORDIC_W-1:0] out_x,
    output logic signed [CORDIC_W-1:0] out_y,
    output logic signed [ANGLE_W-1:0]  out_z,
    output logic                       out_neg,
    output logic                       out_degen
);
    logic signed [CORDIC_W-1:0] x_next, y_next;
    logic signed [ANGLE_W-1:0]  z_next;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  a;

    always_comb
    begin
        dx = in_y >>> STEP;
        dy = in_x >>> STEP;
        a  = atan_lut(5'(STEP));
        if (in_y >= 0)
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + a;
        end
        else
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x     <= x_next;
            out_y     <= y_next;
            out_z     <= z_next;
            out_neg   <= in_neg;
            out_degen <= in_degen;
        end
    end
endmodule

// File: src/dihedral_front.sv
// vector front end: bond vectors, normals, triple product, scaling, x and |m|^2
// depends on dihedral_pkg
module dihedral_front
    import dihedral_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] p [12],
    output logic                          out_valid,
    output logic signed [CORDIC_W-1:0]    out_x,
    output logic [63:0]                   out_q,
    output logic [6:0]                    out_s,
    output logic                          out_neg,
    output logic                          out_degen
);
    localparam int BW = COORD_WIDTH + 1;
    localparam int PW = 2 * BW;
    localparam int NW = PW + 1;
    localparam int TW = BW + NW + 2;
    localparam int LW = NW / 2;
    localparam int HW = NW - LW;

    // stage 1: bond vectors
    logic signed [BW-1:0] b1_reg [3], b2_reg [3], b3_reg [3];
    logic v1_reg;
    // stage 2: products
    logic signed [PW-1:0] pa_reg [3], pb_reg [3], pc_reg [3], pd_reg [3];
    logic signed [BW-1:0] b1d_reg [3];
    logic v2_reg;
    // stage 3: normals
    logic signed [NW-1:0] n1_reg [3], n2_reg [3];
    logic signed [BW-1:0] b1e_reg [3];
    logic v3_reg;
    // stage 4: triple product partial terms, scaled normals, degenerate
    logic signed [BW+LW:0] tl_reg [3];
    logic signed [BW+HW-1:0] th_reg [3];
    logic signed [NORM_EXP:0] u_reg [3], w_reg [3];
    logic dg4_reg, v4_reg;
    // stage 5: scaled products
    logic signed [2*NORM_EXP+1:0] xp_reg [3], ma_reg [3], mb_reg [3];
    logic ng5_reg, dg5_reg, v5_reg;
    // stage 6: x and cross of scaled normals
    logic signed [CORDIC_W-1:0] x6_reg;
    logic signed [2*NORM_EXP+2:0] m_reg [3];
    logic ng6_reg, dg6_reg, v6_reg;
    // stage 7: reduced cross
    logic signed [CORDIC_W-1:0] x7_reg;
    logic signed [CROSS_EXP:0] mr_reg [3];
    logic [6:0] s7_reg;
    logic ng7_reg, dg7_reg, v7_reg;

    function automatic logic [6:0] norm_shift(input logic signed [NW-1:0] a,
                                              input logic signed [NW-1:0] b,
                                              input logic signed [NW-1:0] c);
        logic [NW-1:0] ma, mb, mc, o;
        logic [6:0] r;
        ma = a[NW-1] ? ~a : a;
        mb = b[NW-1] ? ~b : b;
        mc = c[NW-1] ? ~c : c;
        o = ma | mb | mc;
        r = '0;
        for (int k = 0; k < NW; k++)
            if (o[k] && k >= NORM_EXP)
                r = 7'(k - NORM_EXP + 1);
        return r;
    endfunction

    function automatic logic [6:0] cross_shift(input logic signed [2*NORM_EXP+2:0] a,
                                               input logic signed [2*NORM_EXP+2:0] b,
                                               input logic signed [2*NORM_EXP+2:0] c);
        logic [2*NORM_EXP+2:0] ma, mb, mc, o;
        logic [6:0] r;
        ma = a[2*NORM_EXP+2] ? ~a : a;
        mb = b[2*NORM_EXP+2] ? ~b : b;
        mc = c[2*NORM_EXP+2] ? ~c : c;
        o = ma | mb | mc;
        r = '0;
        for (int k = 0; k < 2*NORM_EXP+3; k++)
            if (o[k] && k >= CROSS_EXP)
                r = 7'(k - CROSS_EXP + 1);
        return r;
    endfunction

    logic [6:0] sh1, sh2, shm;
    logic signed [NW-1:0] n1s [3], n2s [3];
    logic signed [2*NORM_EXP+2:0] ms [3];
    logic signed [TW-1:0] tsum;
    logic [63:0] q;

    always_comb
    begin
        sh1 = norm_shift(n1_reg[0], n1_reg[1], n1_reg[2]);
        sh2 = norm_shift(n2_reg[0], n2_reg[1], n2_reg[2]);
        shm = cross_shift(m_reg[0], m_reg[1], m_reg[2]);
        tsum = '0;
        for (int k = 0; k < 3; k++)
        begin
            n1s[k] = n1_reg[k] >>> sh1;
            n2s[k] = n2_reg[k] >>> sh2;
            ms[k]  = m_reg[k] >>> shm;
            tsum = tsum + (TW'(th_reg[k]) <<< LW) + TW'(tl_reg[k]);
        end
        q = 64'(mr_reg[0]) * 64'(mr_reg[0]) + 64'(mr_reg[1]) * 64'(mr_reg[1])
            + 64'(mr_reg[2]) * 64'(mr_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg; v6_reg <= v5_reg;
            v7_reg <= v6_reg; out_valid <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                b1_reg[k] <= BW'(p[3+k]) - BW'(p[k]);
                b2_reg[k] <= BW'(p[6+k]) - BW'(p[3+k]);
                b3_reg[k] <= BW'(p[9+k]) - BW'(p[6+k]);
                b1d_reg[k] <= b1_reg[k];
                b1e_reg[k] <= b1d_reg[k];
            end
            pa_reg[0] <= b1_reg[1] * b2_reg[2]; pb_reg[0] <= b1_reg[2] * b2_reg[1];
            pa_reg[1] <= b1_reg[2] * b2_reg[0]; pb_reg[1] <= b1_reg[0] * b2_reg[2];
            pa_reg[2] <= b1_reg[0] * b2_reg[1]; pb_reg[2] <= b1_reg[1] * b2_reg[0];
            pc_reg[0] <= b2_reg[1] * b3_reg[2]; pd_reg[0] <= b2_reg[2] * b3_reg[1];
            pc_reg[1] <= b2_reg[2] * b3_reg[0]; pd_reg[1] <= b2_reg[0] * b3_reg[2];
            pc_reg[2] <= b2_reg[0] * b3_reg[1]; pd_reg[2] <= b2_reg[1] * b3_reg[0];
            for (int k = 0; k < 3; k++)
            begin
                n1_reg[k] <= NW'(pa_reg[k]) - NW'(pb_reg[k]);
                n2_reg[k] <= NW'(pc_reg[k]) - NW'(pd_reg[k]);
                tl_reg[k] <= b1e_reg[k] * $signed({1'b0, n2_reg[k][LW-1:0]});
                th_reg[k] <= b1e_reg[k] * $signed(n2_reg[k][NW-1:LW]);
                u_reg[k] <= (NORM_EXP+1)'(n1s[k]);
                w_reg[k] <= (NORM_EXP+1)'(n2s[k]);
            end
            dg4_reg <= (n1_reg[0] == 0 && n1_reg[1] == 0 && n1_reg[2] == 0) ||
                       (n2_reg[0] == 0 && n2_reg[1] == 0 && n2_reg[2] == 0);
            for (int k = 0; k < 3; k++)
                xp_reg[k] <= u_reg[k] * w_reg[k];
            ma_reg[0] <= u_reg[1] * w_reg[2]; mb_reg[0] <= u_reg[2] * w_reg[1];
            ma_reg[1] <= u_reg[2] * w_reg[0]; mb_reg[1] <= u_reg[0] * w_reg[2];
            ma_reg[2] <= u_reg[0] * w_reg[1]; mb_reg[2] <= u_reg[1] * w_reg[0];
            ng5_reg <= tsum[TW-1];
            dg5_reg <= dg4_reg;
            x6_reg <= CORDIC_W'(xp_reg[0]) + CORDIC_W'(xp_reg[1]) + CORDIC_W'(xp_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                m_reg[k] <= (2*NORM_EXP+3)'(ma_reg[k]) - (2*NORM_EXP+3)'(mb_reg[k]);
                mr_reg[k] <= (CROSS_EXP+1)'(ms[k]);
            end
            ng6_reg <= ng5_reg; dg6_reg <= dg5_reg;
            x7_reg <= x6_reg; s7_reg <= shm;
            ng7_reg <= ng6_reg; dg7_reg <= dg6_reg;
            out_x <= x7_reg; out_q <= q; out_s <= s7_reg;
            out_neg <= ng7_reg; out_degen <= dg7_reg;
        end
    end
endmodule

// File: src/dihedral_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on dihedral_pkg
module dihedral_sqrt
    import dihedral_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [CORDIC_W-1:0] in_x,
    input  logic [63:0]                in_q,
    input  logic [6:0]                 in_s,
    input  logic                       in_neg,
    input  logic                       in_degen,
    output logic                       out_valid,
    output logic signed [CORDIC_W-1:0] out_x,
    output logic signed [CORDIC_W-1:0] out_y,
    output logic                       out_fold,
    output logic                       out_neg,
    output logic                       out_degen
);
    localparam int N = 32;

    logic [63:0] rem_reg [N+1];
    logic [31:0] root_reg [N+1];
    logic signed [CORDIC_W-1:0] x_reg [N+1];
    logic [6:0] s_reg [N+1];
    logic ng_reg [N+1], dg_reg [N+1], v_reg [N+1];

    always_comb
    begin
        rem_reg[0] = in_q; root_reg[0] = '0; x_reg[0] = in_x; s_reg[0] = in_s;
        ng_reg[0] = in_neg; dg_reg[0] = in_degen; v_reg[0] = in_valid;
    end

    for (genvar g = 0; g < N; g++)
    begin : g_bit
        localparam int B = N - 1 - g;
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [31:0] root_next;
        always_comb
        begin
            trial = (64'(root_reg[g]) << (B + 1)) | (64'd1 << (2 * B));
            if (rem_reg[g] >= trial)
            begin
                rem_next = rem_reg[g] - trial;
                root_next = root_reg[g] | (32'd1 << B);
            end
            else
            begin
                rem_next = rem_reg[g];
                root_next = root_reg[g];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g+1] <= 1'b0;
            else if (en)
                v_reg[g+1] <= v_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g+1] <= rem_next; root_reg[g+1] <= root_next;
                x_reg[g+1] <= x_reg[g]; s_reg[g+1] <= s_reg[g];
                ng_reg[g+1] <= ng_reg[g]; dg_reg[g+1] <= dg_reg[g];
            end
        end
    end

    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [CORDIC_W-1:0] tmp;
    assign tmp = CORDIC_W'(root_reg[N]);
    assign y_sh = tmp << s_reg[N][4:0];

    // quadrant fold for negative x
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_reg[N] < 0)
            begin
                out_x <= y_sh;
                out_y <= -x_reg[N];
            end
            else
            begin
                out_x <= x_reg[N];
                out_y <= y_sh;
            end
            out_fold <= x_reg[N] < 0;
            out_neg <= ng_reg[N];
            out_degen <= dg_reg[N];
        end
    end
endmodule
